// File: rtl/core/shdlc_enc_pkg.sv
// shared types, constants and byte-stuffing helpers for the shdlc frame encoder
package shdlc_enc_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] XON_BYTE     = 8'h11;
  localparam logic [7:0] XOFF_BYTE    = 8'h13;
  localparam logic [7:0] SUB_FLAG     = 8'h5E;
  localparam logic [7:0] SUB_ESC      = 8'h5D;
  localparam logic [7:0] SUB_XON      = 8'h31;
  localparam logic [7:0] SUB_XOFF     = 8'h33;
  localparam logic [7:0] LEN_WITH_ARG = 8'h02;
  localparam logic [7:0] LEN_BARE     = 8'h00;

  localparam int unsigned CmdWidth = 8;
  localparam int unsigned ArgWidth = 16;
  localparam int unsigned InDataWidth = CmdWidth + ArgWidth;

  // one frame, fully classified, waiting for the serializer
  typedef struct packed {
    logic       func;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] arg_hi;
    logic [7:0] arg_lo;
    logic [7:0] chk;
  } frame_desc_t;

  function automatic logic needs_esc(input logic [7:0] b);
    logic r;
    r = (b == FLAG_BYTE) || (b == ESC_BYTE) || (b == XON_BYTE) || (b == XOFF_BYTE);
    return r;
  endfunction

  function automatic logic [7:0] esc_sub(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      FLAG_BYTE: r = SUB_FLAG;
      ESC_BYTE:  r = SUB_ESC;
      XON_BYTE:  r = SUB_XON;
      XOFF_BYTE: r = SUB_XOFF;
      default:   r = b;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/shdlc_enc_front.sv
// request intake: builds the frame descriptor and checksum, one register stage
module shdlc_enc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic                       req_func_i,
  input  logic [7:0]                 req_cmd_i,
  input  logic [15:0]                req_arg_i,
  input  logic [7:0]                 addr_i,
  output logic                       desc_valid_o,
  input  logic                       desc_ready_i,
  output shdlc_enc_pkg::frame_desc_t desc_o
);

  logic                       valid_q, valid_d;
  shdlc_enc_pkg::frame_desc_t desc_q, desc_d;
  logic [7:0]                 len;
  logic [7:0]                 hi_term;
  logic [7:0]                 lo_term;
  logic [7:0]                 sum;
  logic                       accept;

  assign req_ready_o = !valid_q || desc_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // argument bytes only count when the request carries them
  assign len     = req_func_i ? shdlc_enc_pkg::LEN_WITH_ARG : shdlc_enc_pkg::LEN_BARE;
  assign hi_term = req_func_i ? req_arg_i[15:8] : 8'h00;
  assign lo_term = req_func_i ? req_arg_i[7:0]  : 8'h00;
  assign sum     = addr_i + req_cmd_i + len + hi_term + lo_term;

  always_comb begin
    valid_d = valid_q;
    desc_d  = desc_q;
    if (accept) begin
      valid_d       = 1'b1;
      desc_d.func   = req_func_i;
      desc_d.addr   = addr_i;
      desc_d.cmd    = req_cmd_i;
      desc_d.arg_hi = req_arg_i[15:8];
      desc_d.arg_lo = req_arg_i[7:0];
      desc_d.chk    = ~sum;
    end else if (desc_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

endmodule

// File: rtl/core/shdlc_enc_queue.sv
// two-entry descriptor queue between intake and serializer
module shdlc_enc_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  shdlc_enc_pkg::frame_desc_t push_desc_i,
  output logic                       head_valid_o,
  output shdlc_enc_pkg::frame_desc_t head_desc_o,
  input  logic                       pop_i
);

  shdlc_enc_pkg::frame_desc_t entry_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 count_q;
  logic                       push;
  logic                       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_desc_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/shdlc_enc_back.sv
// serializer: walks the frame byte by byte and inserts escape sequences
module shdlc_enc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  shdlc_enc_pkg::frame_desc_t head_desc_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [7:0]                 m_data_o,
  output logic                       m_last_o
);

  typedef enum logic [2:0] {
    ST_SOF,
    ST_ADDR,
    ST_CMD,
    ST_LEN,
    ST_HI,
    ST_LO,
    ST_CHK,
    ST_EOF
  } step_e;

  step_e      step_q, step_d, step_nxt;
  logic       esc_q, esc_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic [7:0] raw;
  logic       stuff;
  logic       load;
  logic       pop;

  assign load = head_valid_i && (!valid_q || m_ready_i);

  always_comb begin
    raw      = shdlc_enc_pkg::FLAG_BYTE;
    stuff    = 1'b0;
    step_nxt = step_q;
    unique case (step_q)
      ST_SOF: begin
        raw      = shdlc_enc_pkg::FLAG_BYTE;
        step_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        raw      = head_desc_i.addr;
        stuff    = 1'b1;
        step_nxt = ST_CMD;
      end
      ST_CMD: begin
        raw      = head_desc_i.cmd;
        stuff    = 1'b1;
        step_nxt = ST_LEN;
      end
      ST_LEN: begin
        raw      = head_desc_i.func ? shdlc_enc_pkg::LEN_WITH_ARG : shdlc_enc_pkg::LEN_BARE;
        step_nxt = head_desc_i.func ? ST_HI : ST_CHK;
      end
      ST_HI: begin
        raw      = head_desc_i.arg_hi;
        stuff    = 1'b1;
        step_nxt = ST_LO;
      end
      ST_LO: begin
        raw      = head_desc_i.arg_lo;
        stuff    = 1'b1;
        step_nxt = ST_CHK;
      end
      ST_CHK: begin
        raw      = head_desc_i.chk;
        stuff    = 1'b1;
        step_nxt = ST_EOF;
      end
      ST_EOF: begin
        raw      = shdlc_enc_pkg::FLAG_BYTE;
        step_nxt = ST_SOF;
      end
    endcase
  end

  always_comb begin
    step_d  = step_q;
    esc_d   = esc_q;
    valid_d = valid_q && !m_ready_i;
    data_d  = data_q;
    last_d  = last_q;
    pop     = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      last_d  = (step_q == ST_EOF);
      pop     = (step_q == ST_EOF);
      if (stuff && esc_q) begin
        // second half of an escape pair
        data_d = shdlc_enc_pkg::esc_sub(raw);
        esc_d  = 1'b0;
        step_d = step_nxt;
      end else if (stuff && shdlc_enc_pkg::needs_esc(raw)) begin
        data_d = shdlc_enc_pkg::ESC_BYTE;
        esc_d  = 1'b1;
      end else begin
        data_d = raw;
        step_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_SOF;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
      data_q  <= 8'h00;
      last_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
      data_q  <= data_d;
      last_q  <= last_d;
    end
  end

  assign pop_o     = pop;
  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

  a_last_is_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (data_q == shdlc_enc_pkg::FLAG_BYTE))
    else $error("frame end without stop flag");

  a_esc_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (valid_q && data_q == shdlc_enc_pkg::ESC_BYTE && !last_q))
    else $error("escape pending without escape byte on output");

  a_pop_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (last_q && step_q == ST_SOF && !esc_q))
    else $error("descriptor released before stop flag");

  a_esc_only_stuffable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (step_q != ST_SOF && step_q != ST_LEN && step_q != ST_EOF))
    else $error("escape pending on an unstuffed byte");

endmodule

// File: rtl/core/shdlc_frame_encoder_core.sv
// top level of the shdlc frame encoder: intake, descriptor queue and serializer
//
// Each accepted request produces one frame on the master stream: start flag 0x7E,
// slave address, command, length (0 or 2), the argument high then low byte when
// tuser is 1, the inverted 8-bit sum of address, command, length and argument as
// checksum, and a 0x7E stop flag marked with tlast. Address, command, argument and
// checksum bytes that equal 0x7E, 0x7D, 0x11 or 0x13 go out as 0x7D followed by
// 0x5E, 0x5D, 0x31 or 0x33. A frame is 6 to 13 bytes and the serializer emits one
// byte per cycle while the sink takes them, and frames follow each other without
// gaps while the next one is already queued. Requests are taken into an intake
// register plus a two-entry queue whose head is the frame being sent, so up to two
// requests can wait behind that frame; a frame's bytes pass through the intake
// register, the queue and the serializer output register. The slave address
// register is written over the cfg channel (always ready) and is sampled when a
// request is taken; it resets to 0 and should only be changed while no frame is
// pending.
module shdlc_frame_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave address register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // command request
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] command, [23:8] argument
  input  logic        s_axis_tuser_i,   // [0] func: 1 when the argument is sent
  // framed byte stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] tx_byte
  output logic        m_axis_tlast_o    // stop flag of the frame
);

  logic [7:0]                 addr_q;
  logic                       front_valid;
  logic                       queue_ready;
  shdlc_enc_pkg::frame_desc_t front_desc;
  logic                       head_valid;
  shdlc_enc_pkg::frame_desc_t head_desc;
  logic                       pop;

  // configuration register, writable at any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 8'h00;
    end else if (cfg_valid_i) begin
      addr_q <= cfg_data_i;
    end
  end

  // intake and checksum
  shdlc_enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_o  (s_axis_tready_o),
    .req_func_i   (s_axis_tuser_i),
    .req_cmd_i    (s_axis_tdata_i[shdlc_enc_pkg::CmdWidth-1:0]),
    .req_arg_i    (s_axis_tdata_i[shdlc_enc_pkg::InDataWidth-1:shdlc_enc_pkg::CmdWidth]),
    .addr_i       (addr_q),
    .desc_valid_o (front_valid),
    .desc_ready_i (queue_ready),
    .desc_o       (front_desc)
  );

  // decouples intake from the byte serializer
  shdlc_enc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_desc_i  (front_desc),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc),
    .pop_i        (pop)
  );

  // byte serializer with escaping, registered output
  shdlc_enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o)
  );

endmodule
